[hdl/nrsh_pkg.sv]
`timescale 1ns / 1ps
package nrsh_pkg;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_CAST   = 2'd2;

  localparam int SPHERE_W = 64;
  localparam int ROOT_W   = 30;
  localparam int REM_W    = 2 * ROOT_W;
  localparam int BEST_W   = 32;

  typedef struct packed {
    logic latch_item;
    logic clear;
    logic insert;
    logic scan_start;
    logic scan_issue;
    logic read_last;
    logic write_last;
    logic load_out;
  } nrsh_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       full;
    logic       empty;
    logic       scan_last;
    logic       pipe_busy;
    logic       best_valid;
    logic       out_free;
  } nrsh_status_t;

endpackage

[hdl/nrsh_ram.sv]
`timescale 1ns / 1ps
module nrsh_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hdl/nrsh_ctrl.sv]
`timescale 1ns / 1ps
module nrsh_ctrl import nrsh_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_stall,
  input  nrsh_status_t status,
  output nrsh_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_READ   = 3'd4;
  localparam logic [2:0] ST_WRITE  = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign item_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.latch_item = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_next = ST_FINISH;
        case (status.action)
          ACT_CLEAR: cmd.clear = 1'b1;
          ACT_INSERT: cmd.insert = !status.full;
          ACT_CAST: begin
            if (!status.empty) begin
              cmd.scan_start = 1'b1;
              state_next = ST_SCAN;
            end
          end
          default: state_next = ST_FINISH;
        endcase
      end
      ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (status.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = status.best_valid ? ST_READ : ST_FINISH;
        end
      end
      ST_READ: begin
        cmd.read_last = 1'b1;
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.write_last = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hdl/nrsh_datapath.sv]
`timescale 1ns / 1ps
module nrsh_datapath import nrsh_pkg::*; #(
  parameter int MAX_SPHERES = 128
) (
  input  logic         clk,
  input  logic         rst,
  input  nrsh_cmd_t    cmd,
  output nrsh_status_t status,
  input  logic [1:0]   action,
  input  logic [15:0]  pos_x,
  input  logic [15:0]  pos_y,
  input  logic [15:0]  pos_z,
  input  logic [15:0]  dir_x,
  input  logic [15:0]  dir_y,
  input  logic [15:0]  dir_z,
  input  logic [15:0]  sphere_radius,
  output logic         result_valid,
  input  logic         result_stall,
  output logic         hit,
  output logic [6:0]   hit_index,
  output logic [23:0]  hit_distance,
  output logic [7:0]   entry_count,
  output logic         table_full
);

  localparam int IW = $clog2(MAX_SPHERES > 1 ? MAX_SPHERES : 2);
  localparam int CW = $clog2(MAX_SPHERES + 1);
  localparam int NSTAGE = 5 + ROOT_W;

  logic [1:0]          item_action;
  logic                item_full;
  logic signed [15:0]  org_x, org_y, org_z, dx, dy, dz;
  logic [15:0]         org_raw_x, org_raw_y, org_raw_z, rad;
  logic [CW-1:0]       count;
  logic [IW-1:0]       scan_idx;
  logic [IW-1:0]       last_idx;
  logic [IW-1:0]       best_idx;

  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  logic [IW-1:0]       rd_addr;
  logic [SPHERE_W-1:0] wr_data;
  logic [SPHERE_W-1:0] rd_data;

  assign last_idx = IW'(count - CW'(1));
  assign wr_en   = cmd.insert || cmd.write_last;
  assign wr_addr = cmd.insert ? count[IW-1:0] : best_idx;
  assign wr_data = cmd.insert ? {rad, org_raw_z, org_raw_y, org_raw_x} : rd_data;
  assign rd_addr = cmd.read_last ? last_idx : scan_idx;

  nrsh_ram #(
    .WIDTH(SPHERE_W),
    .DEPTH(MAX_SPHERES)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      item_action <= action;
      item_full <= status.full;
      org_raw_x <= pos_x;
      org_raw_y <= pos_y;
      org_raw_z <= pos_z;
      dx <= dir_x;
      dy <= dir_y;
      dz <= dir_z;
      rad <= sphere_radius;
    end
  end

  assign org_x = org_raw_x;
  assign org_y = org_raw_y;
  assign org_z = org_raw_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.insert) begin
      count <= count + CW'(1);
    end else if (cmd.write_last) begin
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_idx <= '0;
    end else if (cmd.scan_issue) begin
      scan_idx <= scan_idx + IW'(1);
    end
  end

  // Stage valid bits and index tags.
  logic [NSTAGE:0] vld;
  logic [IW-1:0]   tag [NSTAGE+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NSTAGE-1:0], cmd.scan_issue};
    end
  end

  always_ff @(posedge clk) begin
    tag[0] <= scan_idx;
    for (int s = 1; s <= NSTAGE; s++) begin
      tag[s] <= tag[s-1];
    end
  end

  // Stage 1: offsets from sphere center.
  logic signed [16:0] ox, oy, oz;
  logic [15:0]        r1;
  always_ff @(posedge clk) begin
    ox <= 17'(org_x) - 17'($signed(rd_data[15:0]));
    oy <= 17'(org_y) - 17'($signed(rd_data[31:16]));
    oz <= 17'(org_z) - 17'($signed(rd_data[47:32]));
    r1 <= rd_data[63:48];
  end

  // Stage 2: products.
  logic signed [33:0] pdx, pdy, pdz, sqx, sqy, sqz;
  logic [31:0]        rsq;
  always_ff @(posedge clk) begin
    pdx <= 34'(ox) * 34'(dx);
    pdy <= 34'(oy) * 34'(dy);
    pdz <= 34'(oz) * 34'(dz);
    sqx <= 34'(ox) * 34'(ox);
    sqy <= 34'(oy) * 34'(oy);
    sqz <= 34'(oz) * 34'(oz);
    rsq <= 32'(r1) * 32'(r1);
  end

  // Stage 3: dot product and |oc|^2 - r^2.
  logic signed [35:0] dot_s;
  logic signed [35:0] csum;
  logic signed [29:0] b3;
  logic signed [35:0] c3;
  assign dot_s = 36'(pdx) + 36'(pdy) + 36'(pdz);
  assign csum  = 36'(sqx) + 36'(sqy) + 36'(sqz) - $signed({4'b0, rsq});
  always_ff @(posedge clk) begin
    b3 <= dot_s[35:6];
    c3 <= csum;
  end

  // Stage 4: b squared.
  logic signed [59:0] bb4;
  logic signed [29:0] b4;
  logic signed [35:0] c4;
  always_ff @(posedge clk) begin
    bb4 <= 60'(b3) * 60'(b3);
    b4 <= b3;
    c4 <= c3;
  end

  // Stage 5: discriminant.
  logic signed [61:0] disc;
  logic [REM_W-1:0]   rem [ROOT_W+1];
  logic [ROOT_W-1:0]  root [ROOT_W+1];
  logic               miss [ROOT_W+1];
  logic signed [29:0] bq [ROOT_W+1];
  assign disc = 62'(bb4) - 62'({c4, 16'b0});
  always_ff @(posedge clk) begin
    rem[0]  <= disc[REM_W-1:0];
    root[0] <= '0;
    miss[0] <= c4[35] || disc[61];
    bq[0]   <= b4;
  end

  // Square root, one result bit per stage.
  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    localparam int K = ROOT_W - 1 - j;
    logic [REM_W+1:0] test;
    assign test = ({{(REM_W+2-ROOT_W){1'b0}}, root[j]} << (K + 1)) +
                  ((REM_W+2)'(1) << (2 * K));
    always_ff @(posedge clk) begin
      if ({2'b0, rem[j]} >= test) begin
        rem[j+1]  <= rem[j] - test[REM_W-1:0];
        root[j+1] <= root[j] | (ROOT_W'(1) << K);
      end else begin
        rem[j+1]  <= rem[j];
        root[j+1] <= root[j];
      end
      miss[j+1] <= miss[j];
      bq[j+1]   <= bq[j];
    end
  end

  // Nearest-hit selection.
  logic signed [BEST_W-1:0] t_cand;
  logic                     cand_ok;
  logic [BEST_W-1:0]        best_t;
  logic                     best_valid;
  assign t_cand  = -BEST_W'(bq[ROOT_W]) - $signed({2'b0, root[ROOT_W]});
  assign cand_ok = vld[NSTAGE] && !miss[ROOT_W] && !t_cand[BEST_W-1];

  always_ff @(posedge clk) begin
    if (rst || cmd.latch_item || cmd.scan_start) begin
      best_valid <= 1'b0;
    end else if (cand_ok && (!best_valid || $unsigned(t_cand) < best_t)) begin
      best_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cand_ok && (!best_valid || $unsigned(t_cand) < best_t)) begin
      best_t   <= $unsigned(t_cand);
      best_idx <= tag[NSTAGE];
    end
  end

  // Result register.
  logic             is_cast;
  logic             res_hit;
  logic [IW+6:0]    idx_ext;
  logic [CW+7:0]    cnt_ext;
  logic [BEST_W-9:0] dist_q;
  assign is_cast = (item_action == ACT_CAST);
  assign res_hit = is_cast && best_valid;
  assign idx_ext = {7'b0, best_idx};
  assign cnt_ext = {8'b0, count};
  assign dist_q  = best_t[BEST_W-1:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      hit          <= res_hit;
      hit_index    <= res_hit ? idx_ext[6:0] : 7'd0;
      hit_distance <= res_hit ? dist_q : 24'd0;
      entry_count  <= cnt_ext[7:0];
      table_full   <= (item_action == ACT_INSERT) && item_full;
    end
  end

  assign status.action     = item_action;
  assign status.full       = (count >= CW'(MAX_SPHERES));
  assign status.empty      = (count == '0);
  assign status.scan_last  = (scan_idx == last_idx);
  assign status.pipe_busy  = |vld;
  assign status.best_valid = best_valid;
  assign status.out_free   = !result_valid || !result_stall;

endmodule

[hdl/nearest_ray_sphere_hit_table.sv]
`timescale 1ns / 1ps
// Channel   Handshake                    Payload
// item      item_valid / item_stall      action, pos_x/y/z, dir_x/y/z, sphere_radius
// result    result_valid / result_stall  hit, hit_index, hit_distance, entry_count, table_full
//
// Clear, insert, an unused action and a cast on an empty table pass from decode to finish and
// show their result from the output register; the next word is taken back in idle.
// A cast over N stored spheres shows its result after the scan and the pipeline drain, and
// on a hit after a read state and a write state more: the scan reads one sphere per cycle, the
// bit-per-stage square root pipeline adds its depth, and a hit moves the last entry into its slot.
// Reset empties the table; no clearing pass is needed.
// A result waits in the output register while stalled, and one more word is taken meanwhile.
module nearest_ray_sphere_hit_table import nrsh_pkg::*; #(
  parameter int MAX_SPHERES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  action,
  input  logic [15:0] pos_x,
  input  logic [15:0] pos_y,
  input  logic [15:0] pos_z,
  input  logic [15:0] dir_x,
  input  logic [15:0] dir_y,
  input  logic [15:0] dir_z,
  input  logic [15:0] sphere_radius,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        hit,
  output logic [6:0]  hit_index,
  output logic [23:0] hit_distance,
  output logic [7:0]  entry_count,
  output logic        table_full
);

  nrsh_cmd_t    cmd;
  nrsh_status_t status;

  nrsh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .status    (status),
    .cmd       (cmd)
  );

  nrsh_datapath #(
    .MAX_SPHERES(MAX_SPHERES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .action       (action),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .dir_x        (dir_x),
    .dir_y        (dir_y),
    .dir_z        (dir_z),
    .sphere_radius(sphere_radius),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .hit          (hit),
    .hit_index    (hit_index),
    .hit_distance (hit_distance),
    .entry_count  (entry_count),
    .table_full   (table_full)
  );

endmodule

[tb/tb_nearest_ray_sphere_hit_table.sv]
`timescale 1ns / 1ps
module tb_nearest_ray_sphere_hit_table;
  import nrsh_pkg::*;

  localparam int TABLE_DEPTH = 128;
  localparam int IDLE_LIMIT  = 20000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] px, py, pz, dx, dy, dz, rad;
  } word_t;

  typedef struct packed {
    logic        hit;
    logic [6:0]  index;
    logic [23:0] distance;
    logic [7:0]  count;
    logic        full;
  } answer_t;

  typedef struct {
    word_t   w;
    bit      typed;
    answer_t a;
  } row_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        item_valid = 0;
  logic        item_stall;
  logic [1:0]  action = '0;
  logic [15:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [15:0] dir_x = '0, dir_y = '0, dir_z = '0, sphere_radius = '0;
  logic        result_valid;
  logic        result_stall = 1;
  logic        hit;
  logic [6:0]  hit_index;
  logic [23:0] hit_distance;
  logic [7:0]  entry_count;
  logic        table_full;

  nearest_ray_sphere_hit_table uut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  logic [63:0] sphere_model [TABLE_DEPTH];
  int          sphere_total;
  answer_t     pending_hits [$];
  int          fail_count;
  int          idle_cycles;
  bit          stim_done;
  bit          hold_off;
  row_t        rows [$];

  function automatic longint sx(logic [15:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint root_floor(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint ray_distance(word_t w, logic [63:0] e);
    longint ox, oy, oz, r, dot, b, c, disc, t;
    ox = sx(w.px) - sx(e[15:0]);
    oy = sx(w.py) - sx(e[31:16]);
    oz = sx(w.pz) - sx(e[47:32]);
    r = longint'(e[63:48]);
    dot = ox * sx(w.dx) + oy * sx(w.dy) + oz * sx(w.dz);
    b = dot >>> 6;
    c = (ox * ox + oy * oy + oz * oz) * 65536 - r * r * 65536;
    if (c < 0) return -1;
    disc = b * b - c;
    if (disc < 0) return -1;
    t = -b - root_floor(disc);
    return (t >= 0) ? t : -1;
  endfunction

  function automatic answer_t predict_hit(word_t w);
    answer_t a;
    longint best, t;
    int best_i;
    a = '0;
    best = -1;
    best_i = 0;
    case (w.action)
      ACT_CLEAR: sphere_total = 0;
      ACT_INSERT: begin
        if (sphere_total >= TABLE_DEPTH) begin
          a.full = 1'b1;
        end else begin
          sphere_model[sphere_total] = {w.rad, w.pz, w.py, w.px};
          sphere_total++;
        end
      end
      ACT_CAST: begin
        for (int i = 0; i < sphere_total; i++) begin
          t = ray_distance(w, sphere_model[i]);
          if (t >= 0 && (best < 0 || t < best)) begin
            best = t;
            best_i = i;
          end
        end
        if (best >= 0) begin
          a.hit = 1'b1;
          a.index = best_i[6:0];
          a.distance = ((best >>> 8) > 64'hFFFFFF) ? 24'hFFFFFF : best[31:8];
          sphere_model[best_i] = sphere_model[sphere_total - 1];
          sphere_total--;
        end
      end
      default: ;
    endcase
    a.count = sphere_total[7:0];
    return a;
  endfunction

  function automatic logic [15:0] rand_dir();
    int v;
    v = $urandom_range(32768) - 16384;
    return v[15:0];
  endfunction

  function automatic word_t rand_word(int insert_weight);
    word_t w;
    int pick;
    pick = $urandom_range(99);
    w.action = (pick < 2) ? ACT_CLEAR : (pick < 3) ? ACT_UNUSED :
               (pick < insert_weight) ? ACT_INSERT : ACT_CAST;
    if ($urandom_range(3) == 0) begin
      w.px = 16'($urandom); w.py = 16'($urandom); w.pz = 16'($urandom);
      w.rad = 16'($urandom);
    end else begin
      w.px = 16'($urandom_range(4095) - 2048);
      w.py = 16'($urandom_range(4095) - 2048);
      w.pz = 16'($urandom_range(4095) - 2048);
      w.rad = 16'($urandom_range(1023));
    end
    case ($urandom_range(3))
      0: begin w.dx = 16'(16384); w.dy = 16'd0; w.dz = 16'd0; end
      1: begin w.dx = rand_dir(); w.dy = rand_dir(); w.dz = rand_dir(); end
      2: begin w.dx = 16'($urandom); w.dy = 16'($urandom); w.dz = 16'($urandom); end
      default: begin w.dx = 16'(11585); w.dy = -16'sd11585; w.dz = 16'd0; end
    endcase
    return w;
  endfunction

  task automatic send_word(word_t w);
    int gap;
    gap = $urandom_range(17);
    if (gap > 0) begin
      item_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1;
    {action, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, sphere_radius} <= w;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pending_hits.push_back(predict_hit(w));
    @(negedge clk);
  endtask

  function automatic row_t mk(logic [1:0] act, int x, int y, int z, int ddx, int ddy,
                              int ddz, int r, bit typed, answer_t a);
    row_t row;
    row.w = {act, x[15:0], y[15:0], z[15:0], ddx[15:0], ddy[15:0], ddz[15:0], r[15:0]};
    row.typed = typed;
    row.a = a;
    return row;
  endfunction

  initial begin
    word_t w;
    for (int i = 0; i < 12; i++) rows.push_back(mk(ACT_CAST, 0, 0, 0, 16384, 0, 0, 0, 1,
                                               '0)); // empty table casts
    rows.push_back(mk(ACT_UNUSED, -32768, 32767, -1, -16384, 16384, -1, 65535, 1, '0));
    rows.push_back(mk(ACT_INSERT, 2560, 0, 0, 0, 0, 0, 256, 1, {32'd0, 8'd1, 1'b0}));
    rows.push_back(mk(ACT_INSERT, 1280, 0, 0, 0, 0, 0, 256, 1, {32'd0, 8'd2, 1'b0}));
    rows.push_back(mk(ACT_INSERT, 0, 0, 0, 0, 0, 0, 512, 0, '0));
    rows.push_back(mk(ACT_CAST, 0, 0, 0, 16384, 0, 0, 0, 0, '0));
    rows.push_back(mk(ACT_CAST, 3840, 0, 0, 16384, 0, 0, 0, 0, '0));
    rows.push_back(mk(ACT_CAST, 0, 2560, 0, 0, 16384, 0, 0, 0, '0));
    rows.push_back(mk(ACT_CAST, -32768, -32768, -32768, 16384, 16384, 16384, 0, 0, '0));
    rows.push_back(mk(ACT_INSERT, 32767, 32767, 32767, 0, 0, 0, 65535, 0, '0));
    rows.push_back(mk(ACT_CAST, -32768, 32767, 32767, 16384, 0, 0, 0, 0, '0));
    rows.push_back(mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 1, '0));
    fail_count = 0;
    sphere_total = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    foreach (rows[k]) begin
      send_word(rows[k].w);
      if (rows[k].typed && pending_hits[$] != rows[k].a) begin
        $error("row %0d typed answer %h, model %h", k, rows[k].a, pending_hits[$]);
        fail_count++;
      end
    end
    for (int i = 0; i < 131; i++) begin
      w = rand_word(100);
      w.action = ACT_INSERT;
      send_word(w);
    end
    hold_off = 1;
    for (int i = 0; i < 8; i++) send_word(rand_word(3));
    for (int i = 0; i < 1800; i++) send_word(rand_word((i % 400 < 200) ? 70 : 40));
    item_valid <= 0;
    stim_done = 1;
  end

  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) begin
        hold_off = 0;
        result_stall <= 1;
        repeat (600) @(negedge clk);
      end
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(17);
      if (gap != 0) begin
        result_stall <= 1;
        repeat (gap) @(negedge clk);
      end
      result_stall <= 0;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    answer_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_hits.size() == 0) begin
        $error("word with nothing expected");
        fail_count++;
      end else begin
        want = pending_hits.pop_front();
        if (hit !== want.hit) begin
          $error("hit expected %0d actual %0d", want.hit, hit); fail_count++;
        end
        if (hit_index !== want.index) begin
          $error("hit_index expected %0d actual %0d", want.index, hit_index); fail_count++;
        end
        if (hit_distance !== want.distance) begin
          $error("hit_distance expected %0d actual %0d", want.distance, hit_distance);
          fail_count++;
        end
        if (entry_count !== want.count) begin
          $error("entry_count expected %0d actual %0d", want.count, entry_count);
          fail_count++;
        end
        if (table_full !== want.full) begin
          $error("table_full expected %0d actual %0d", want.full, table_full); fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    @(negedge rst);
    while (!(stim_done && pending_hits.size() == 0) && idle_cycles < IDLE_LIMIT)
      @(posedge clk);
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
    end else begin
      repeat (200) @(posedge clk);
      if (fail_count == 0 && pending_hits.size() == 0)
        $display("DONE: 0 errors");
      else
        $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
hdl/nrsh_pkg.sv
hdl/nrsh_ram.sv
hdl/nrsh_ctrl.sv
hdl/nrsh_datapath.sv
hdl/nearest_ray_sphere_hit_table.sv
tb/tb_nearest_ray_sphere_hit_table.sv
